// ===== hw/rtl/ray_quad_intersect_macros.svh =====
// Assertion helpers for the ray/quad intersection block.
`ifndef RAY_QUAD_INTERSECT_MACROS_SVH
`define RAY_QUAD_INTERSECT_MACROS_SVH
`ifndef SYNTHESIS
`define RQI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rqi assertion failed");
`define RQI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rqi assertion failed");
`else
`define RQI_ASSERT_IMP(lbl, ante, cons)
`define RQI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/rqi_pkg.sv =====
package rqi_pkg;

  localparam int COORD_W    = 16;
  localparam int WORD_W     = 3 * COORD_W;
  localparam int IN_W       = 6 * WORD_W;
  localparam int OUT_W      = 56;
  localparam int E_W        = COORD_W + 1;
  localparam int PROD_W     = 2 * E_W;
  localparam int N_W        = PROD_W + 2;
  localparam int DOT_W      = 56;
  localparam int DEN_W      = DOT_W - 1;
  localparam int REM_W      = DEN_W + 1;
  localparam int T_FRAC     = 30;
  localparam int T_W        = T_FRAC + 1;
  localparam int DIV_STAGES = T_W;
  localparam int P_W        = COORD_W + 2;
  localparam int NUM_EDGES  = 6;

  localparam logic [1:0] EDGE_FROM [NUM_EDGES] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};
  localparam logic [1:0] EDGE_TO   [NUM_EDGES] = '{2'd1, 2'd2, 2'd0, 2'd2, 2'd3, 2'd0};

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    DROP_X = 2'd0,
    DROP_Y = 2'd1,
    DROP_Z = 2'd2
  } axis_t;

  typedef struct packed {
    logic          miss;
    axis_t         axis;
    coord_t [2:0]  s;
    coord_t [2:0]  r;
    coord_t [3:0]  cu;
    coord_t [3:0]  cv;
  } pay_t;

  typedef struct packed {
    pay_t              pay;
    logic [DEN_W-1:0]  num;
    logic [DEN_W-1:0]  den;
  } qent_t;

  function automatic coord_t ck(input logic [WORD_W-1:0] w, input logic [1:0] k);
    ck = coord_t'(w[COORD_W*k +: COORD_W]);
  endfunction

  function automatic logic [1:0] proj_u(input axis_t ax);
    case (ax)
      DROP_X:  proj_u = 2'd1;
      default: proj_u = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] proj_v(input axis_t ax);
    case (ax)
      DROP_Z:  proj_v = 2'd1;
      default: proj_v = 2'd2;
    endcase
  endfunction

endpackage

// ===== hw/rtl/rqi_front.sv =====
`include "ray_quad_intersect_macros.svh"
module rqi_front import rqi_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [IN_W-1:0] in_data,
  input  logic            q_full,
  output logic            push,
  output qent_t           push_ent
);

  logic fadv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [IN_W-1:0] d1_r, d2_r, d3_r, d4_r, d5_r;

  logic signed [E_W-1:0]    e1_r [3];
  logic signed [E_W-1:0]    e2_r [3];
  logic signed [E_W-1:0]    as1_r [3];
  logic signed [E_W-1:0]    as2_r [3];
  logic signed [E_W-1:0]    as3_r [3];
  logic signed [PROD_W-1:0] pa_r [3];
  logic signed [PROD_W-1:0] pb_r [3];
  logic signed [N_W-1:0]    n_r [3];
  logic signed [N_W+15:0]   dp_r [3];
  logic signed [N_W+16:0]   np_r [3];
  axis_t                    ax4_r, ax5_r;
  logic signed [DOT_W-1:0]  den_r, num_r;

  logic [N_W-1:0]          mg [3];
  axis_t                   ax_nxt;
  logic                    dneg;
  logic signed [DOT_W-1:0] dmag, nadj;

  function automatic logic [WORD_W-1:0] wd(input logic [IN_W-1:0] d, input int i);
    wd = d[WORD_W*i +: WORD_W];
  endfunction

  assign fadv     = !v5_r || !q_full;
  assign in_ready = fadv;
  assign push     = v5_r && !q_full;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mg[k] = n_r[k][N_W-1] ? N_W'(-n_r[k]) : N_W'(n_r[k]);
    end
    if (mg[0] > mg[1] && mg[0] > mg[2]) begin
      ax_nxt = DROP_X;
    end else if (mg[1] > mg[0] && mg[1] > mg[2]) begin
      ax_nxt = DROP_Y;
    end else begin
      ax_nxt = DROP_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (fadv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
    if (fadv) begin
      d1_r <= in_data;
      d2_r <= d1_r;
      d3_r <= d2_r;
      d4_r <= d3_r;
      d5_r <= d4_r;
      for (int k = 0; k < 3; k++) begin
        e1_r[k]  <= E_W'(ck(wd(in_data, 3), 2'(k))) - E_W'(ck(wd(in_data, 2), 2'(k)));
        e2_r[k]  <= E_W'(ck(wd(in_data, 4), 2'(k))) - E_W'(ck(wd(in_data, 2), 2'(k)));
        as1_r[k] <= E_W'(ck(wd(in_data, 2), 2'(k))) - E_W'(ck(wd(in_data, 0), 2'(k)));
        as2_r[k] <= as1_r[k];
        as3_r[k] <= as2_r[k];
        n_r[k]   <= N_W'(pa_r[k]) - N_W'(pb_r[k]);
        dp_r[k]  <= n_r[k] * ck(wd(d3_r, 1), 2'(k));
        np_r[k]  <= n_r[k] * as3_r[k];
      end
      pa_r[0] <= e1_r[1] * e2_r[2];
      pb_r[0] <= e1_r[2] * e2_r[1];
      pa_r[1] <= e1_r[2] * e2_r[0];
      pb_r[1] <= e1_r[0] * e2_r[2];
      pa_r[2] <= e1_r[0] * e2_r[1];
      pb_r[2] <= e1_r[1] * e2_r[0];
      ax4_r   <= ax_nxt;
      ax5_r   <= ax4_r;
      den_r   <= DOT_W'(dp_r[0]) + DOT_W'(dp_r[1]) + DOT_W'(dp_r[2]);
      num_r   <= DOT_W'(np_r[0]) + DOT_W'(np_r[1]) + DOT_W'(np_r[2]);
    end
  end

  always_comb begin
    dneg = den_r[DOT_W-1];
    dmag = dneg ? -den_r : den_r;
    nadj = dneg ? -num_r : num_r;
    push_ent.pay.miss = (den_r == '0) || (nadj <= 0) || (nadj > dmag);
    push_ent.pay.axis = ax5_r;
    for (int k = 0; k < 3; k++) begin
      push_ent.pay.s[k] = ck(wd(d5_r, 0), 2'(k));
      push_ent.pay.r[k] = ck(wd(d5_r, 1), 2'(k));
    end
    for (int i = 0; i < 4; i++) begin
      push_ent.pay.cu[i] = ck(wd(d5_r, i + 2), proj_u(ax5_r));
      push_ent.pay.cv[i] = ck(wd(d5_r, i + 2), proj_v(ax5_r));
    end
    push_ent.num = nadj[DEN_W-1:0];
    push_ent.den = dmag[DEN_W-1:0];
  end

  `RQI_ASSERT_IMP(fr_quot_range, push && !push_ent.pay.miss, push_ent.num <= push_ent.den)

endmodule

// ===== hw/rtl/rqi_queue.sv =====
`include "ray_quad_intersect_macros.svh"
module rqi_queue import rqi_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t wr_ent,
  output logic  full,
  input  logic  pop,
  output qent_t rd_ent,
  output logic  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qent_t          mem [DEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [CW-1:0]  count_r;

  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);
  assign rd_ent = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `RQI_ASSERT_IMP(q_no_overflow, push, !full)
  `RQI_ASSERT_IMP(q_no_underflow, pop, !empty)
  `RQI_ASSERT_NXT(q_count_up, push && !pop, count_r == CW'($past(count_r) + 1'b1))

endmodule

// ===== hw/rtl/rqi_back.sv =====
`include "ray_quad_intersect_macros.svh"
module rqi_back import rqi_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   q_empty,
  input  qent_t  q_head,
  output logic   pop,
  output logic   out_valid,
  input  logic   out_ready,
  output logic   out_hit,
  output coord_t out_cx,
  output coord_t out_cy,
  output coord_t out_cz
);

  localparam int MP_W = COORD_W + T_W + 2;
  localparam logic signed [MP_W-1:0] ROUND_HALF = MP_W'(1) <<< (T_FRAC - 1);
  localparam int W_W = P_W + 1;
  localparam int M_W = E_W + W_W;

  logic adv;

  logic             dv_r  [DIV_STAGES];
  logic [REM_W-1:0] rem_r [DIV_STAGES];
  logic [T_W-1:0]   q_r   [DIV_STAGES];
  logic [DEN_W-1:0] dd_r  [DIV_STAGES];
  pay_t             dp_r  [DIV_STAGES];

  logic                    vm_r, vp_r, vc_r;
  pay_t                    pm_r, pp_r, pc_r;
  logic signed [MP_W-1:0]  mp_r [3];
  logic signed [P_W-1:0]   p_r  [3];
  logic signed [P_W-1:0]   pc_p_r [3];
  logic signed [E_W-1:0]   dx_r [NUM_EDGES];
  logic signed [W_W-1:0]   w_r  [NUM_EDGES];
  logic signed [M_W-1:0]   m1_r [NUM_EDGES];
  logic signed [M_W-1:0]   m2_r [NUM_EDGES];

  logic                    out_valid_r, hit_r;
  coord_t                  cx_r, cy_r, cz_r;

  logic signed [P_W-1:0]   pu, pv;
  logic signed [E_W-1:0]   dx_n [NUM_EDGES];
  logic signed [E_W-1:0]   dy_n [NUM_EDGES];
  logic signed [W_W-1:0]   w_n  [NUM_EDGES];
  logic signed [W_W-1:0]   h_n  [NUM_EDGES];
  logic signed [M_W:0]     side [NUM_EDGES];
  logic [NUM_EDGES-1:0]    cr;
  logic                    hit_n;

  function automatic coord_t sat(input logic signed [P_W-1:0] v);
    if (v[P_W-1:COORD_W-1] == '0 || v[P_W-1:COORD_W-1] == '1) begin
      sat = coord_t'(v[COORD_W-1:0]);
    end else if (v[P_W-1]) begin
      sat = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  assign adv = !out_valid_r || out_ready;
  assign pop = adv && !q_empty;

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic             vin, ge;
    logic [REM_W-1:0] rin;
    logic [T_W-1:0]   qin;
    logic [DEN_W-1:0] din;
    pay_t             pin;
    if (j == 0) begin : g_first
      always_comb begin
        vin = pop;
        pin = q_head.pay;
        din = q_head.den;
        rin = REM_W'(q_head.num);
        qin = '0;
      end
    end else begin : g_next
      always_comb begin
        vin = dv_r[j-1];
        pin = dp_r[j-1];
        din = dd_r[j-1];
        rin = {rem_r[j-1][REM_W-2:0], 1'b0};
        qin = q_r[j-1];
      end
    end
    assign ge = (rin >= REM_W'(din));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (adv) begin
        dv_r[j] <= vin;
      end
      if (adv) begin
        rem_r[j] <= ge ? rin - REM_W'(din) : rin;
        q_r[j]   <= {qin[T_W-2:0], ge};
        dd_r[j]  <= din;
        dp_r[j]  <= pin;
      end
    end
  end

  always_comb begin
    pu = p_r[proj_u(pp_r.axis)];
    pv = p_r[proj_v(pp_r.axis)];
    for (int e = 0; e < NUM_EDGES; e++) begin
      dx_n[e] = E_W'(pp_r.cu[EDGE_TO[e]]) - E_W'(pp_r.cu[EDGE_FROM[e]]);
      dy_n[e] = E_W'(pp_r.cv[EDGE_TO[e]]) - E_W'(pp_r.cv[EDGE_FROM[e]]);
      w_n[e]  = W_W'(pu) - W_W'(pp_r.cu[EDGE_FROM[e]]);
      h_n[e]  = W_W'(pv) - W_W'(pp_r.cv[EDGE_FROM[e]]);
    end
  end

  always_comb begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      side[e] = (M_W + 1)'(m1_r[e]) - (M_W + 1)'(m2_r[e]);
      if (dx_r[e] > 0) begin
        cr[e] = (w_r[e] >= 0) && (w_r[e] <= W_W'(dx_r[e])) && (side[e] <= 0);
      end else if (dx_r[e] < 0) begin
        cr[e] = (w_r[e] <= 0) && (w_r[e] >= W_W'(dx_r[e])) && (side[e] >= 0);
      end else begin
        cr[e] = 1'b0;
      end
    end
    hit_n = !pc_r.miss && ((cr[0] ^ cr[1] ^ cr[2]) || (cr[3] ^ cr[4] ^ cr[5]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r        <= 1'b0;
      vp_r        <= 1'b0;
      vc_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vm_r        <= dv_r[DIV_STAGES-1];
      vp_r        <= vm_r;
      vc_r        <= vp_r;
      out_valid_r <= vc_r;
    end
    if (adv) begin
      pm_r <= dp_r[DIV_STAGES-1];
      pp_r <= pm_r;
      pc_r <= pp_r;
      for (int k = 0; k < 3; k++) begin
        mp_r[k]   <= dp_r[DIV_STAGES-1].r[k] * $signed({1'b0, q_r[DIV_STAGES-1]})
                     + ROUND_HALF;
        p_r[k]    <= P_W'(pm_r.s[k]) + $signed(mp_r[k][T_FRAC+P_W-1:T_FRAC]);
        pc_p_r[k] <= p_r[k];
      end
      for (int e = 0; e < NUM_EDGES; e++) begin
        dx_r[e] <= dx_n[e];
        w_r[e]  <= w_n[e];
        m1_r[e] <= dx_n[e] * h_n[e];
        m2_r[e] <= dy_n[e] * w_n[e];
      end
      hit_r <= hit_n;
      cx_r  <= hit_n ? sat(pc_p_r[0]) : '0;
      cy_r  <= hit_n ? sat(pc_p_r[1]) : '0;
      cz_r  <= hit_n ? sat(pc_p_r[2]) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = hit_r;
  assign out_cx    = cx_r;
  assign out_cy    = cy_r;
  assign out_cz    = cz_r;

  `RQI_ASSERT_IMP(bk_miss_zero, out_valid_r && !hit_r, cx_r == '0 && cy_r == '0 && cz_r == '0)

endmodule

// ===== hw/rtl/ray_quad_intersect.sv =====
// Segment-versus-quad hit test on signed Q8.8 coordinates. One transaction is
// taken every cycle while both sides flow; each one passes through five
// plane-setup stages, the queue, a 31-stage restoring divider for t that
// retires one quotient bit per stage, and four stages for contact point,
// edge crossings and output. The front builds the plane and flags misses,
// the back divides and tests inside; a short queue between them lets each
// side stall on its own.
module ray_quad_intersect import rqi_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // ray_start, ray_dir, corner_a, corner_b, corner_c, corner_d
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // hit, contact_x, contact_y, contact_z, zero fill
  output logic [OUT_W-1:0] out_tdata
);

  logic   q_full, q_empty, push, pop;
  qent_t  push_ent, head_ent;
  logic   hit;
  coord_t cx, cy, cz;

  rqi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_tdata),
    .q_full   (q_full),
    .push     (push),
    .push_ent (push_ent)
  );

  rqi_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_ent (push_ent),
    .full   (q_full),
    .pop    (pop),
    .rd_ent (head_ent),
    .empty  (q_empty)
  );

  rqi_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (head_ent),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_hit   (hit),
    .out_cx    (cx),
    .out_cy    (cy),
    .out_cz    (cz)
  );

  assign out_tdata = {(OUT_W - 3 * COORD_W - 1)'(0), cz, cy, cx, hit};

endmodule
